/* design/bpui_pkg.sv */
// Package: widths, defaults and constants of the byte predictor unfilter block.
package bpui_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 17;

    // Default largest chunk in bytes
    localparam int DEFAULT_MAX_CHUNK_BYTES = 65536;

    // Predictor bias; subtracting it mod 256 equals adding it
    localparam logic [BYTE_W-1:0] BIAS = 8'd128;

    // Reset value of the chunk length register
    localparam logic [CFG_W-1:0] CFG_RESET_LENGTH = 17'd1;

endpackage

/* design/bpui_if.sv */
// Interfaces: filtered byte input channel and rebuilt byte result channel.
interface bpui_in_if;
    import bpui_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface bpui_out_if;
    import bpui_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              chunk_last;

    modport source (output valid, output out_byte, output run_last, output chunk_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input chunk_last,
                    output ready);
endinterface

/* design/byte_predictor_unfilter_interleave.sv */
// Top level: predictor unfilter with half interleave over a byte half store.
// First-half items without a result are taken one per cycle while no emit job is pending;
// a second-half item releases its stored byte, then its own byte, and the last item of an
// odd chunk also the tail byte, all paced by the single read port of the half store and
// the one-item result register. Results go via the job registers to the result register.
// Reset (rst_n low, async): position, previous byte and control clear, len_cfg_reg = 1;
// the half store is not cleared and holds stale data until written.
module byte_predictor_unfilter_interleave #(
    parameter int MAX_CHUNK_BYTES = bpui_pkg::DEFAULT_MAX_CHUNK_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bpui_pkg::CFG_W-1:0] cfg_data,
    bpui_in_if.sink                    filtered,
    bpui_out_if.source                 rebuilt
);
    import bpui_pkg::*;

    localparam int STORE_DEPTH = (MAX_CHUNK_BYTES + 1) / 2;
    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LEN_W = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    // Emit sequencer steps
    localparam logic [1:0] STEP_STORED = 2'd0;
    localparam logic [1:0] STEP_OWN    = 2'd1;
    localparam logic [1:0] STEP_TAIL   = 2'd2;

    logic [CFG_W-1:0]  len_cfg_reg;
    logic [LEN_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] prev_reg;

    logic              job_valid_reg;
    logic [1:0]        step_reg;
    logic [BYTE_W-1:0] job_byte_reg;
    logic              job_last_reg;
    logic              job_tail_reg;
    logic [AW-1:0]     tail_addr_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              chunk_last_reg;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [CMP_W-1:0]  cfg_ext;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  half;
    logic [LEN_W-1:0]  pos_eff;
    logic [LEN_W-1:0]  pos_next;
    logic [LEN_W-1:0]  rank;
    logic              is_last;
    logic              is_odd;
    logic              first_half;
    logic [BYTE_W-1:0] rebuilt_byte;

    logic              accept;
    logic              out_load;
    logic              job_final;
    logic              job_free;
    logic              tail_rd;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;

    logic [BYTE_W-1:0] sel_byte;
    logic              sel_run_last;
    logic              sel_chunk_last;

    // Effective chunk length and half size
    always_comb
    begin
        cfg_ext = CMP_W'(len_cfg_reg);
        if (cfg_ext == '0)
            len = LEN_W'(1);
        else if (cfg_ext > CMP_W'(MAX_CHUNK_BYTES))
            len = LEN_W'(MAX_CHUNK_BYTES);
        else
            len = LEN_W'(cfg_ext);
    end

    assign half   = LEN_W'(({1'b0, len} + {{LEN_W{1'b0}}, 1'b1}) >> 1);
    assign is_odd = len[0];

    // Position bookkeeping and predictor
    assign pos_eff    = (pos_reg >= len) ? '0 : pos_reg;
    assign is_last    = ((pos_eff + LEN_W'(1)) == len);
    assign pos_next   = is_last ? '0 : pos_eff + LEN_W'(1);
    assign first_half = (pos_eff < half);
    assign rank       = pos_eff - half;

    assign rebuilt_byte = (pos_eff == '0) ? filtered.in_byte
                                          : prev_reg + filtered.in_byte + BIAS;

    // Handshake and emit control
    assign out_load  = job_valid_reg && (!out_valid_reg || rebuilt.ready);
    assign job_final = (step_reg == STEP_TAIL) || ((step_reg == STEP_OWN) && !job_tail_reg);
    assign job_free  = !job_valid_reg || (out_load && job_final);
    assign filtered.ready = job_free;
    assign accept    = filtered.valid && job_free;
    assign tail_rd   = out_load && (step_reg == STEP_OWN) && job_tail_reg;

    // Half store port control
    assign mem_we    = accept && first_half;
    assign mem_waddr = pos_eff[AW-1:0];
    assign mem_re    = (accept && !first_half) || tail_rd;
    assign mem_raddr = (accept && !first_half) ? rank[AW-1:0] : tail_addr_reg;

    // Half store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= rebuilt_byte;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    // Result selection per step
    always_comb
    begin
        unique case (step_reg)
            STEP_STORED:
            begin
                sel_byte       = rdata_reg;
                sel_run_last   = 1'b0;
                sel_chunk_last = 1'b0;
            end
            STEP_OWN:
            begin
                sel_byte       = job_byte_reg;
                sel_run_last   = !job_tail_reg;
                sel_chunk_last = job_last_reg && !job_tail_reg;
            end
            STEP_TAIL:
            begin
                sel_byte       = rdata_reg;
                sel_run_last   = 1'b1;
                sel_chunk_last = 1'b1;
            end
            default:
            begin
                sel_byte       = rdata_reg;
                sel_run_last   = 1'b1;
                sel_chunk_last = 1'b1;
            end
        endcase
    end

    // Configuration register and predictor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= CFG_RESET_LENGTH;
            pos_reg     <= '0;
            prev_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                len_cfg_reg <= cfg_data;
            if (accept)
            begin
                pos_reg  <= pos_next;
                prev_reg <= rebuilt_byte;
            end
        end
    end

    // Emit sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            step_reg      <= STEP_STORED;
        end
        else if (accept && !first_half)
        begin
            job_valid_reg <= 1'b1;
            step_reg      <= STEP_STORED;
        end
        else if (accept && is_last)
        begin
            // single-byte chunk: its own byte goes out once
            job_valid_reg <= 1'b1;
            step_reg      <= STEP_OWN;
        end
        else if (out_load)
        begin
            if (job_final)
                job_valid_reg <= 1'b0;
            else if (step_reg == STEP_STORED)
                step_reg <= STEP_OWN;
            else
                step_reg <= STEP_TAIL;
        end
    end

    // Job payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_byte_reg  <= rebuilt_byte;
            job_last_reg  <= is_last;
            job_tail_reg  <= is_last && is_odd && !first_half;
            tail_addr_reg <= AW'(half - LEN_W'(1));
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rebuilt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg   <= sel_byte;
            run_last_reg   <= sel_run_last;
            chunk_last_reg <= sel_chunk_last;
        end
    end

    assign rebuilt.valid      = out_valid_reg;
    assign rebuilt.out_byte   = out_byte_reg;
    assign rebuilt.run_last   = run_last_reg;
    assign rebuilt.chunk_last = chunk_last_reg;

    // Checks
    a_tail_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && (step_reg == STEP_TAIL)) |-> job_tail_reg)
        else $error("tail step without tail flag");

    a_tail_read_then_tail: assert property (@(posedge clk) disable iff (!rst_n)
        tail_rd |=> (job_valid_reg && (step_reg == STEP_TAIL)))
        else $error("tail read not followed by tail step");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < LEN_W'(MAX_CHUNK_BYTES))
        else $error("position beyond largest chunk");

    a_chunk_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && chunk_last_reg) |-> run_last_reg)
        else $error("chunk end without run end");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        tail_rd |-> !accept)
        else $error("tail read collides with item read");

endmodule

/* dv/testbench.sv */
// Testbench: byte predictor unfilter with half interleave, table-driven and random streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpui_pkg::*;

    localparam int MAX_BYTES      = DEFAULT_MAX_CHUNK_BYTES;
    localparam int HALF_DEPTH     = (MAX_BYTES + 1) / 2;
    localparam int RANDOM_ITEMS   = 188;
    localparam int STEADY_FROM    = 150;
    // results pass through the job and result registers; leave margin before a length write
    localparam int SETTLE_CYCLES  = 6;
    localparam int END_CYCLES     = 20;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              chunk_last;
    } result_t;

    typedef enum bit {ROW_ITEM, ROW_LENGTH} row_kind_t;

    // One table row: an item (value = byte) or a length write (value = length)
    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_W-1:0]  value;
        bit                typed;
        logic [BYTE_W-1:0] expected;
    } row_t;

    localparam int NUM_ROWS = 30;

    // Typed rows run at length 1: the byte comes straight back as the last of its chunk
    row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ITEM,   17'h00,     1'b1, 8'h00},
        '{ROW_ITEM,   17'hFF,     1'b1, 8'hFF},
        '{ROW_ITEM,   17'h80,     1'b1, 8'h80},
        '{ROW_LENGTH, 17'd0,      1'b0, 8'h00},   // zero length acts as one
        '{ROW_ITEM,   17'h5A,     1'b1, 8'h5A},
        '{ROW_LENGTH, 17'd2,      1'b0, 8'h00},
        '{ROW_ITEM,   17'h10,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h80,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'd3,      1'b0, 8'h00},   // odd chunk: tail byte
        '{ROW_ITEM,   17'h00,     1'b0, 8'h00},
        '{ROW_ITEM,   17'hFF,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h7F,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'd8,      1'b0, 8'h00},
        '{ROW_ITEM,   17'h40,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h81,     1'b0, 8'h00},
        '{ROW_ITEM,   17'hC3,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'd5,      1'b0, 8'h00},   // shrink mid-chunk into second half
        '{ROW_ITEM,   17'h01,     1'b0, 8'h00},
        '{ROW_ITEM,   17'hFE,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'd65536,  1'b0, 8'h00},   // largest chunk
        '{ROW_ITEM,   17'h22,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h90,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h7E,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'h1FFFF,  1'b0, 8'h00},   // above range, clamps to largest
        '{ROW_ITEM,   17'hEE,     1'b0, 8'h00},
        '{ROW_LENGTH, 17'd4,      1'b0, 8'h00},   // position past length: new chunk
        '{ROW_ITEM,   17'h33,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h99,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h80,     1'b0, 8'h00},
        '{ROW_ITEM,   17'h00,     1'b0, 8'h00}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    bpui_in_if  filtered_ch ();
    bpui_out_if rebuilt_ch ();

    byte_predictor_unfilter_interleave dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .filtered (filtered_ch),
        .rebuilt  (rebuilt_ch)
    );

    // Predictor state
    logic [CFG_W-1:0]  chunk_len_reg;
    int unsigned       chunk_pos;
    logic [BYTE_W-1:0] prev_byte;
    logic [BYTE_W-1:0] half_mem [HALF_DEPTH];

    result_t expected_bytes [$];

    // Run control and counters
    bit sender_gaps;
    bit receiver_stalls;
    bit steady;
    bit long_hold_req;
    int stall_left;
    int hold_left;
    int idle_cycles;
    int mismatches;
    int results_seen;
    int directed_items;
    int random_items;
    int length_settings;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_len(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_BYTES)
            return MAX_BYTES;
        return v;
    endfunction

    // Rebuild one byte and return the bytes it releases
    function automatic int unfilter_step(input logic [BYTE_W-1:0] b, output result_t res [3]);
        int unsigned       len;
        int unsigned       half;
        logic [BYTE_W-1:0] r;
        bit                last;
        bit                tail;
        int                n;
        len = eff_len(chunk_len_reg);
        half = (len + 1) / 2;
        n = 0;
        if (chunk_pos >= len)
            chunk_pos = 0;
        last = (chunk_pos + 1 == len);
        r = (chunk_pos == 0) ? b : BYTE_W'(prev_byte + b - BIAS);
        prev_byte = r;
        if (chunk_pos < half)
        begin
            half_mem[chunk_pos] = r;
            if (last)
            begin
                res[0] = '{r, 1'b1, 1'b1};
                n = 1;
            end
        end
        else
        begin
            tail = last && len[0];
            res[0] = '{half_mem[chunk_pos - half], 1'b0, 1'b0};
            res[1] = '{r, !tail, last && !tail};
            n = 2;
            if (tail)
            begin
                res[2] = '{half_mem[half - 1], 1'b1, 1'b1};
                n = 3;
            end
        end
        chunk_pos = last ? 0 : chunk_pos + 1;
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic check_result();
        result_t want;
        results_seen++;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("result %0d with nothing expected (byte 0x%02h)",
                                      results_seen, rebuilt_ch.out_byte));
            return;
        end
        want = expected_bytes.pop_front();
        if (rebuilt_ch.out_byte !== want.out_byte)
            report_mismatch($sformatf("result %0d out_byte 0x%02h, expected 0x%02h",
                                      results_seen, rebuilt_ch.out_byte, want.out_byte));
        if (rebuilt_ch.run_last !== want.run_last)
            report_mismatch($sformatf("result %0d run_last %b, expected %b",
                                      results_seen, rebuilt_ch.run_last, want.run_last));
        if (rebuilt_ch.chunk_last !== want.chunk_last)
            report_mismatch($sformatf("result %0d chunk_last %b, expected %b",
                                      results_seen, rebuilt_ch.chunk_last, want.chunk_last));
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // Length write only once the block has gone quiet
    task automatic write_length(input logic [CFG_W-1:0] v);
        filtered_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        chunk_len_reg = v;
        length_settings++;
    endtask

    // Offer one item, wait for accept, then queue what it should release
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input logic [BYTE_W-1:0] typed_byte);
        int      gap;
        int      n;
        result_t res [3];
        gap = 0;
        if (!steady && sender_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            filtered_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        filtered_ch.valid   <= 1'b1;
        filtered_ch.in_byte <= b;
        @(posedge clk);
        while (!filtered_ch.ready)
            @(posedge clk);
        n = unfilter_step(b, res);
        if (typed)
            expected_bytes.push_back('{typed_byte, 1'b1, 1'b1});
        else
            for (int i = 0; i < n; i++)
                expected_bytes.push_back(res[i]);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return BIAS;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Receiver: checks results and drives ready with stall bursts and one long hold
    always @(posedge clk)
    begin
        if (rst_n && rebuilt_ch.valid && rebuilt_ch.ready)
            check_result();
        if (hold_left > 0)
        begin
            hold_left--;
            rebuilt_ch.ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rebuilt_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rebuilt_ch.ready <= 1'b0;
        end
        else if (!steady && receiver_stalls && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            rebuilt_ch.ready <= 1'b0;
        end
        else
            rebuilt_ch.ready <= 1'b1;
    end

    // Watchdog: cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if ((filtered_ch.valid && filtered_ch.ready) || (rebuilt_ch.valid && rebuilt_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [CFG_W-1:0] new_len;
        int unsigned      cur_eff;
        int unsigned      len;
        int               count;
        bit               hold_done;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        filtered_ch.valid   = 1'b0;
        filtered_ch.in_byte = '0;
        rebuilt_ch.ready    = 1'b0;
        sender_gaps         = 1'b1;
        receiver_stalls     = 1'b1;
        steady              = 1'b0;
        long_hold_req       = 1'b0;
        hold_done           = 1'b0;
        stall_left          = 0;
        hold_left           = 0;
        idle_cycles         = 0;
        mismatches          = 0;
        results_seen        = 0;
        directed_items      = 0;
        random_items        = 0;
        length_settings     = 0;
        chunk_len_reg       = CFG_RESET_LENGTH;
        chunk_pos           = 0;
        prev_byte           = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LENGTH)
                write_length(directed_rows[i].value);
            else
            begin
                send_byte(directed_rows[i].value[BYTE_W-1:0], directed_rows[i].typed,
                          directed_rows[i].expected);
                directed_items++;
            end
        end

        // Random phases: a length, then a run of bytes under it
        while (random_items < RANDOM_ITEMS)
        begin
            cur_eff = eff_len(chunk_len_reg);
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0: new_len = CFG_W'(MAX_BYTES);
                        1: new_len = '1;
                        2: new_len = CFG_W'($urandom_range(MAX_BYTES + 1, 17'h1FFFE));
                        default: new_len = CFG_W'($urandom_range(1000, MAX_BYTES - 1));
                    endcase
                end
                1: new_len = '0;
                2: new_len = CFG_W'($urandom_range(13, 40));
                default: new_len = CFG_W'($urandom_range(1, 12));
            endcase
            if (!hold_done && random_items >= 60)
                new_len = 17'd4;
            // growing mid-chunk could read store entries never written
            if (chunk_pos != 0 && eff_len(new_len) > cur_eff)
                new_len = CFG_W'($urandom_range(1, (cur_eff < 12) ? cur_eff : 12));
            len = eff_len(new_len);
            if (len >= 1000)
                count = $urandom_range(1, 6);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 2 * len);
            else
                count = len * $urandom_range(1, 3);

            sender_gaps     = $urandom_range(0, 2) != 0;
            receiver_stalls = $urandom_range(0, 2) != 0;
            write_length(new_len);

            // long receiver hold while the sender keeps offering
            if (!hold_done && random_items >= 60)
            begin
                hold_done = 1'b1;
                count = 24;
                long_hold_req = 1'b1;
            end
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;

            repeat (count)
            begin
                if (random_items >= STEADY_FROM)
                    steady = 1'b1;
                send_byte(pick_byte(), 1'b0, 8'h00);
                random_items++;
            end
        end

        filtered_ch.valid <= 1'b0;
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("Run covered %0d directed and %0d random items over %0d length settings,",
                 directed_items, random_items, length_settings);
        $display("with lengths 0, 1, 65536 and above range, mid-chunk shrinks; %0d results checked",
                 results_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
